FILE: rtl/hierarchical_message_rate_limiter_macros.svh
// Assertion helpers for the rate limiter checker.
`ifndef HIERARCHICAL_MESSAGE_RATE_LIMITER_MACROS_SVH
`define HIERARCHICAL_MESSAGE_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define HMRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define HMRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hmrl_pkg.sv
package hmrl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int TABLES = 3;

  localparam int SKEY_W = 64;
  localparam int IKEY_W = 64;
  localparam int MKEY_W = 32;
  localparam int RATE_W = 16;
  localparam int TIME_W = 64;
  localparam int LVL_W  = 26;
  localparam int KEY_W  = SKEY_W + MKEY_W;
  localparam int PROD_W = LVL_W + RATE_W;
  localparam int WORD_W = KEY_W + LVL_W + TIME_W;
  localparam int REASON_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [9:0] MILLI = 10'd1000;

  localparam logic [RATE_W-1:0] SESSION_RATE_RST   = 16'd80;
  localparam logic [RATE_W-1:0] SESSION_BURST_RST  = 16'd160;
  localparam logic [RATE_W-1:0] INSTANCE_RATE_RST  = 16'd160;
  localparam logic [RATE_W-1:0] INSTANCE_BURST_RST = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SESSION_RATE   = 2'd0,
    CFG_SESSION_BURST  = 2'd1,
    CFG_INSTANCE_RATE  = 2'd2,
    CFG_INSTANCE_BURST = 2'd3
  } cfg_idx_t;

  localparam logic [REASON_W-1:0] R_NONE     = 3'd0;
  localparam logic [REASON_W-1:0] R_MESSAGE  = 3'd1;
  localparam logic [REASON_W-1:0] R_SESSION  = 3'd2;
  localparam logic [REASON_W-1:0] R_INSTANCE = 3'd3;
  localparam logic [REASON_W-1:0] R_FULL     = 3'd4;

  typedef enum logic [1:0] {
    STG_SESS = 2'd0,
    STG_MSG  = 2'd1,
    STG_INST = 2'd2
  } stage_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MATH1,
    ST_MATH2,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                load;
    logic                scan_start;
    logic                scan_run;
    logic                bkt_load;
    logic                fresh;
    logic                math1;
    logic                math2;
    logic                write;
    logic                out_load;
    stage_t              stage;
    logic [REASON_W-1:0] reason;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic hit;
    logic last;
    logic free_ok;
    logic pass;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/hierarchical_message_rate_limiter.sv
// Hierarchical message rate limiter.
// Input channel (in_valid/in_ready): one item asks to admit one message for a
// session, a (session, message id) pair and an instance. Each is checked in
// turn against its own token bucket table; an unknown key claims the lowest
// free slot and starts full.
// Result channel (out_valid/out_ready): one item per input, out_allowed and
// out_reason (none, message/invalid, session, instance, table full).
// Config port: cfg_we writes cfg_data into the register at cfg_index
// (session rate, session burst, instance rate, instance burst); write only
// while no item is in flight.
// Steps: an invalid item goes from the check straight to the result; otherwise
// each consulted table costs one scan through the shared slot RAM read port
// plus the refill math (MATH1, MATH2, WRITE). One item at a time; the next
// is taken only after the result is loaded into the output register.
// The scan of the slot RAM, one entry per cycle, sets the rate.
// Reset (synchronous, rst_n low) restores the register defaults and marks
// every slot free at once; no clearing pass is needed.
// A finished result waits in the output register while the next item is
// taken; a stalled receiver holds the block only when the following result
// is ready too.
module hierarchical_message_rate_limiter #(
  parameter int TABLE_ENTRIES = hmrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hmrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hmrl_pkg::RATE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hmrl_pkg::SKEY_W-1:0]    in_session_key,
  input  logic [hmrl_pkg::IKEY_W-1:0]    in_instance_key,
  input  logic [hmrl_pkg::MKEY_W-1:0]    in_message_key,
  input  logic [hmrl_pkg::RATE_W-1:0]    in_message_rate,
  input  logic [hmrl_pkg::TIME_W-1:0]    in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_allowed,
  output logic [hmrl_pkg::REASON_W-1:0]  out_reason
);

  hmrl_pkg::cmd_t    cmd;
  hmrl_pkg::status_t sts;

  hmrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hmrl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_session_key  (in_session_key),
    .in_instance_key (in_instance_key),
    .in_message_key  (in_message_key),
    .in_message_rate (in_message_rate),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_allowed     (out_allowed),
    .out_reason      (out_reason),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: rtl/hmrl_ram.sv
module hmrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hmrl_ctrl.sv
module hmrl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hmrl_pkg::status_t sts,
  output hmrl_pkg::cmd_t    cmd
);

  hmrl_pkg::state_t state_r, state_nxt;
  hmrl_pkg::stage_t stage_r, stage_nxt;
  logic [hmrl_pkg::REASON_W-1:0] reason_r, reason_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hmrl_pkg::ST_IDLE;
      stage_r  <= hmrl_pkg::STG_SESS;
      reason_r <= hmrl_pkg::R_NONE;
    end else begin
      state_r  <= state_nxt;
      stage_r  <= stage_nxt;
      reason_r <= reason_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    stage_nxt  = stage_r;
    reason_nxt = reason_r;
    cmd        = '0;
    cmd.stage  = stage_r;
    cmd.reason = reason_r;
    in_ready   = 1'b0;
    unique case (state_r)
      hmrl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = hmrl_pkg::ST_CHECK;
        end
      end
      hmrl_pkg::ST_CHECK: begin
        if (sts.invalid) begin
          reason_nxt = hmrl_pkg::R_MESSAGE;
          state_nxt  = hmrl_pkg::ST_DONE;
        end else begin
          stage_nxt      = hmrl_pkg::STG_SESS;
          cmd.stage      = hmrl_pkg::STG_SESS;
          cmd.scan_start = 1'b1;
          state_nxt      = hmrl_pkg::ST_SCAN;
        end
      end
      hmrl_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        priority if (sts.hit) begin
          cmd.bkt_load = 1'b1;
          state_nxt    = hmrl_pkg::ST_MATH1;
        end else if (sts.last && sts.free_ok) begin
          cmd.bkt_load = 1'b1;
          cmd.fresh    = 1'b1;
          state_nxt    = hmrl_pkg::ST_MATH1;
        end else if (sts.last) begin
          reason_nxt = hmrl_pkg::R_FULL;
          state_nxt  = hmrl_pkg::ST_DONE;
        end else begin
          state_nxt = hmrl_pkg::ST_SCAN;
        end
      end
      hmrl_pkg::ST_MATH1: begin
        cmd.math1 = 1'b1;
        state_nxt = hmrl_pkg::ST_MATH2;
      end
      hmrl_pkg::ST_MATH2: begin
        cmd.math2 = 1'b1;
        state_nxt = hmrl_pkg::ST_WRITE;
      end
      hmrl_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        if (!sts.pass) begin
          unique case (stage_r)
            hmrl_pkg::STG_SESS: reason_nxt = hmrl_pkg::R_SESSION;
            hmrl_pkg::STG_MSG:  reason_nxt = hmrl_pkg::R_MESSAGE;
            hmrl_pkg::STG_INST: reason_nxt = hmrl_pkg::R_INSTANCE;
            default:            reason_nxt = hmrl_pkg::R_MESSAGE;
          endcase
          state_nxt = hmrl_pkg::ST_DONE;
        end else if (stage_r == hmrl_pkg::STG_INST) begin
          reason_nxt = hmrl_pkg::R_NONE;
          state_nxt  = hmrl_pkg::ST_DONE;
        end else begin
          // advance to the next table
          stage_nxt = (stage_r == hmrl_pkg::STG_SESS) ? hmrl_pkg::STG_MSG
                                                      : hmrl_pkg::STG_INST;
          state_nxt = hmrl_pkg::ST_SCAN;
        end
      end
      hmrl_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = hmrl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hmrl_pkg::ST_IDLE;
    endcase
    // a new scan starts whenever the stage changes after a passing write
    if (state_r == hmrl_pkg::ST_WRITE && sts.pass && stage_r != hmrl_pkg::STG_INST) begin
      cmd.scan_start = 1'b1;
    end
  end

endmodule

FILE: rtl/hmrl_dp.sv
module hmrl_dp #(
  parameter int TABLE_ENTRIES = hmrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [hmrl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hmrl_pkg::RATE_W-1:0]           cfg_data,
  input  logic [hmrl_pkg::SKEY_W-1:0]           in_session_key,
  input  logic [hmrl_pkg::IKEY_W-1:0]           in_instance_key,
  input  logic [hmrl_pkg::MKEY_W-1:0]           in_message_key,
  input  logic [hmrl_pkg::RATE_W-1:0]           in_message_rate,
  input  logic [hmrl_pkg::TIME_W-1:0]           in_now_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_allowed,
  output logic [hmrl_pkg::REASON_W-1:0]         out_reason,
  input  hmrl_pkg::cmd_t                        cmd,
  output hmrl_pkg::status_t                     sts
);

  localparam int N     = TABLE_ENTRIES;
  localparam int IW    = (N > 1) ? $clog2(N) : 1;
  localparam int CW    = $clog2(N + 1);
  localparam int DEPTH = hmrl_pkg::TABLES * N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] BASE_MSG  = AW'(N);
  localparam logic [AW-1:0] BASE_INST = AW'(2 * N);
  localparam logic [CW-1:0] CNT_END   = CW'(N);
  localparam logic [IW-1:0] IDX_LAST  = IW'(N - 1);
  localparam int LW = hmrl_pkg::LVL_W;
  localparam int TW = hmrl_pkg::TIME_W;
  localparam int PW = hmrl_pkg::PROD_W;
  localparam int KW = hmrl_pkg::KEY_W;

  // Configuration registers
  logic [hmrl_pkg::RATE_W-1:0] sess_rate_r, sess_burst_r, inst_rate_r, inst_burst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_rate_r  <= hmrl_pkg::SESSION_RATE_RST;
      sess_burst_r <= hmrl_pkg::SESSION_BURST_RST;
      inst_rate_r  <= hmrl_pkg::INSTANCE_RATE_RST;
      inst_burst_r <= hmrl_pkg::INSTANCE_BURST_RST;
    end else if (cfg_we) begin
      unique case (hmrl_pkg::cfg_idx_t'(cfg_index))
        hmrl_pkg::CFG_SESSION_RATE:   sess_rate_r  <= cfg_data;
        hmrl_pkg::CFG_SESSION_BURST:  sess_burst_r <= cfg_data;
        hmrl_pkg::CFG_INSTANCE_RATE:  inst_rate_r  <= cfg_data;
        hmrl_pkg::CFG_INSTANCE_BURST: inst_burst_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item
  logic [hmrl_pkg::SKEY_W-1:0] skey_r;
  logic [hmrl_pkg::IKEY_W-1:0] ikey_r;
  logic [hmrl_pkg::MKEY_W-1:0] mkey_r;
  logic [hmrl_pkg::RATE_W-1:0] mrate_r;
  logic [TW-1:0]               now_r;
  logic                        invalid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      skey_r    <= in_session_key;
      ikey_r    <= in_instance_key;
      mkey_r    <= in_message_key;
      mrate_r   <= in_message_rate;
      now_r     <= in_now_ms;
      invalid_r <= (in_session_key == '0) || (in_instance_key == '0) ||
                   (in_message_key == '0) || (in_message_rate == '0) ||
                   (in_now_ms == '0);
    end
  end

  // Per-stage key, rate, burst and table base
  logic [KW-1:0]               stage_key;
  logic [hmrl_pkg::RATE_W-1:0] stage_rate, stage_burst;
  logic [AW-1:0]               stage_base;
  logic [N-1:0]                used_sess_r, used_msg_r, used_inst_r, used_vec;

  always_comb begin
    unique case (cmd.stage)
      hmrl_pkg::STG_MSG: begin
        stage_key   = {mkey_r, skey_r};
        stage_rate  = mrate_r;
        stage_burst = {mrate_r[hmrl_pkg::RATE_W-2:0], 1'b0};
        stage_base  = BASE_MSG;
        used_vec    = used_msg_r;
      end
      hmrl_pkg::STG_INST: begin
        stage_key   = {hmrl_pkg::MKEY_W'(0), ikey_r};
        stage_rate  = inst_rate_r;
        stage_burst = inst_burst_r;
        stage_base  = BASE_INST;
        used_vec    = used_inst_r;
      end
      default: begin
        stage_key   = {hmrl_pkg::MKEY_W'(0), skey_r};
        stage_rate  = sess_rate_r;
        stage_burst = sess_burst_r;
        stage_base  = '0;
        used_vec    = used_sess_r;
      end
    endcase
  end

  logic [LW-1:0] stage_ceil;
  assign stage_ceil = LW'(stage_burst) * LW'(hmrl_pkg::MILLI);

  // Scan counters: issue one read per cycle, compare the one before
  logic [CW-1:0] rd_idx_r;
  logic [IW-1:0] cmp_idx_r, free_idx_r;
  logic          cmp_vld_r, free_vld_r;
  logic          issue;
  logic [KW-1:0] rd_key;
  logic [LW-1:0] rd_lvl;
  logic [TW-1:0] rd_last;
  logic [hmrl_pkg::WORD_W-1:0] rd_word;
  logic          cmp_used;

  assign issue    = cmd.scan_run && (rd_idx_r < CNT_END);
  assign {rd_key, rd_lvl, rd_last} = rd_word;
  assign cmp_used = used_vec[cmp_idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      cmp_vld_r  <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_idx_r   <= '0;
      cmp_vld_r  <= 1'b0;
      free_vld_r <= 1'b0;
    end else if (cmd.scan_run) begin
      if (issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      cmp_vld_r <= issue;
      // remember the lowest free slot
      if (cmp_vld_r && !cmp_used && !free_vld_r) begin
        free_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx_r <= rd_idx_r[IW-1:0];
    end
    if (cmd.scan_run && cmp_vld_r && !cmp_used && !free_vld_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  assign sts.hit     = cmp_vld_r && cmp_used && (rd_key == stage_key);
  assign sts.last    = cmp_vld_r && (cmp_idx_r == IDX_LAST);
  assign sts.free_ok = free_vld_r || (cmp_vld_r && !cmp_used);

  // Bucket operands
  logic [IW-1:0]               slot_r;
  logic [LW-1:0]               cur_r, ceil_r, lvl_r;
  logic [TW-1:0]               last_r;
  logic                        fresh_r, back_r, sat_r;
  logic [PW-1:0]               prod_r;
  logic [TW-1:0]               elapsed;
  logic [PW:0]                 sum;
  logic                        take;
  logic [LW-1:0]               new_lvl;

  assign elapsed = now_r - last_r;
  assign sum     = (PW + 1)'(cur_r) + (PW + 1)'(prod_r);
  assign take    = lvl_r >= LW'(hmrl_pkg::MILLI);
  assign new_lvl = take ? (lvl_r - LW'(hmrl_pkg::MILLI)) : lvl_r;

  always_ff @(posedge clk) begin
    // load a matched slot or a freshly claimed one
    if (cmd.bkt_load) begin
      fresh_r <= cmd.fresh;
      ceil_r  <= stage_ceil;
      if (cmd.fresh) begin
        slot_r <= free_vld_r ? free_idx_r : cmp_idx_r;
        cur_r  <= stage_ceil;
        last_r <= now_r;
      end else begin
        slot_r <= cmp_idx_r;
        cur_r  <= rd_lvl;
        last_r <= rd_last;
      end
    end
    // elapsed time times rate, saturating flag for huge gaps
    if (cmd.math1) begin
      back_r <= now_r < last_r;
      sat_r  <= (stage_rate != '0) && (elapsed[TW-1:LW] != '0);
      prod_r <= PW'(elapsed[LW-1:0]) * PW'(stage_rate);
    end
    // refill capped at the ceiling
    if (cmd.math2) begin
      if (cur_r >= ceil_r || sat_r || sum >= (PW + 1)'(ceil_r)) begin
        lvl_r <= ceil_r;
      end else begin
        lvl_r <= sum[LW-1:0];
      end
    end
  end

  assign sts.pass = !back_r && (take || fresh_r);

  // Slot write-back
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  assign ram_we    = cmd.write && !back_r;
  assign ram_waddr = stage_base + AW'(slot_r);
  assign ram_raddr = stage_base + AW'(rd_idx_r[IW-1:0]);

  hmrl_ram #(
    .WIDTH (hmrl_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({stage_key, new_lvl, now_r}),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  // Slot occupancy bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_sess_r <= '0;
      used_msg_r  <= '0;
      used_inst_r <= '0;
    end else if (cmd.write && fresh_r) begin
      unique case (cmd.stage)
        hmrl_pkg::STG_MSG:  used_msg_r[slot_r]  <= 1'b1;
        hmrl_pkg::STG_INST: used_inst_r[slot_r] <= 1'b1;
        default:            used_sess_r[slot_r] <= 1'b1;
      endcase
    end
  end

  // Result register
  logic                          out_valid_r, out_allowed_r;
  logic [hmrl_pkg::REASON_W-1:0] out_reason_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_allowed_r <= cmd.reason == hmrl_pkg::R_NONE;
      out_reason_r  <= cmd.reason;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_allowed  = out_allowed_r;
  assign out_reason   = out_reason_r;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign sts.invalid  = invalid_r;

endmodule

FILE: rtl/hmrl_checker.sv
`include "hierarchical_message_rate_limiter_macros.svh"

module hmrl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_allowed,
  input logic [hmrl_pkg::REASON_W-1:0] out_reason
);

  // Admitted items carry no reason, rejected ones always do
  `HMRL_ASSERT_NOW(a_allow_reason, out_valid, out_allowed == (out_reason == hmrl_pkg::R_NONE), "allowed and reason disagree")

  // Reason code stays within the defined set
  `HMRL_ASSERT_NOW(a_reason_range, out_valid, out_reason == hmrl_pkg::R_NONE || out_reason == hmrl_pkg::R_MESSAGE || out_reason == hmrl_pkg::R_SESSION || out_reason == hmrl_pkg::R_INSTANCE || out_reason == hmrl_pkg::R_FULL, "reason out of range")

  // One item at a time: no new item right after one is taken
  `HMRL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "item accepted back to back")

  // A stalled result holds
  `HMRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_reason) && $stable(out_allowed), "stalled result changed")

endmodule

bind hierarchical_message_rate_limiter hmrl_checker u_hmrl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_allowed (out_allowed),
  .out_reason  (out_reason)
);

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hmrl_pkg::*;

  localparam int SLOTS = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                  allowed;
    logic [REASON_W-1:0]   reason;
  } verdict_t;

  typedef struct {
    bit                    used;
    logic [SKEY_W-1:0]     key;
    logic [MKEY_W-1:0]     id;
    logic [LVL_W-1:0]      level;
    logic [TIME_W-1:0]     last_ms;
  } slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_SESSION_RATE;
  logic [RATE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SKEY_W-1:0] in_session_key = '0;
  logic [IKEY_W-1:0] in_instance_key = '0;
  logic [MKEY_W-1:0] in_message_key = '0;
  logic [RATE_W-1:0] in_message_rate = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_allowed;
  logic [REASON_W-1:0] out_reason;

  hierarchical_message_rate_limiter i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_session_key(in_session_key), .in_instance_key(in_instance_key),
    .in_message_key(in_message_key), .in_message_rate(in_message_rate),
    .in_now_ms(in_now_ms), .out_valid(out_valid), .out_ready(out_ready),
    .out_allowed(out_allowed), .out_reason(out_reason)
  );

  always #5 clk = ~clk;

  // shadow of the block's registers and tables
  logic [RATE_W-1:0] sess_rate_q, sess_burst_q, inst_rate_q, inst_burst_q;
  slot_t sess_tab[SLOTS];
  slot_t msg_tab[SLOTS];
  slot_t inst_tab[SLOTS];

  verdict_t pending_verdicts[$];
  int errors = 0;
  longint unsigned cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit recv_hold = 1'b0;

  // random time base and key pools for the stimulus
  logic [TIME_W-1:0] clock_ms;
  logic [SKEY_W-1:0] sess_pool[8];
  logic [IKEY_W-1:0] inst_pool[8];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // refill, then take one token; returns 1 when taken
  function automatic bit take_token(inout logic [LVL_W-1:0] level,
                                    inout logic [TIME_W-1:0] last_ms,
                                    input logic [RATE_W-1:0] rate,
                                    input logic [RATE_W-1:0] burst,
                                    input logic [TIME_W-1:0] now);
    logic [63:0] ceiling, cur, elapsed, refill;
    logic [127:0] prod;
    ceiling = 64'(burst) * 64'd1000;
    cur = 64'(level);
    if (now < last_ms) return 1'b0;
    elapsed = now - last_ms;
    prod = 128'(elapsed) * 128'(rate);
    if (rate == '0) refill = '0;
    else if (prod[127:64] != '0) refill = ceiling;
    else refill = prod[63:0];
    if (cur >= ceiling || refill >= ceiling - cur) cur = ceiling;
    else cur = cur + refill;
    last_ms = now;
    if (cur < 64'd1000) begin
      level = LVL_W'(cur);
      return 1'b0;
    end
    level = LVL_W'(cur - 64'd1000);
    return 1'b1;
  endfunction

  // one table stage: hit refills and takes, miss claims lowest free slot
  function automatic logic [REASON_W-1:0] run_stage(ref slot_t tab[SLOTS],
                                                    input logic [SKEY_W-1:0] key,
                                                    input logic [MKEY_W-1:0] id,
                                                    input logic [RATE_W-1:0] rate,
                                                    input logic [RATE_W-1:0] burst,
                                                    input logic [TIME_W-1:0] now,
                                                    input logic [REASON_W-1:0] deny);
    int free_slot;
    bit ok;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tab[i].used && tab[i].key == key && tab[i].id == id) begin
        ok = take_token(tab[i].level, tab[i].last_ms, rate, burst, now);
        return ok ? R_NONE : deny;
      end
      if (!tab[i].used && free_slot < 0) free_slot = i;
    end
    if (free_slot < 0) return R_FULL;
    tab[free_slot].used = 1'b1;
    tab[free_slot].key = key;
    tab[free_slot].id = id;
    tab[free_slot].level = LVL_W'(64'(burst) * 64'd1000);
    tab[free_slot].last_ms = now;
    ok = take_token(tab[free_slot].level, tab[free_slot].last_ms, rate, burst, now);
    return R_NONE;
  endfunction

  function automatic verdict_t admit_message(input logic [SKEY_W-1:0] skey,
                                             input logic [IKEY_W-1:0] ikey,
                                             input logic [MKEY_W-1:0] mkey,
                                             input logic [RATE_W-1:0] mrate,
                                             input logic [TIME_W-1:0] now);
    verdict_t v;
    logic [REASON_W-1:0] r;
    logic [RATE_W-1:0] mburst;
    mburst = RATE_W'({mrate, 1'b0});
    if (skey == '0 || ikey == '0 || mkey == '0 || mrate == '0 || now == '0) begin
      r = R_MESSAGE;
    end else begin
      r = run_stage(sess_tab, skey, '0, sess_rate_q, sess_burst_q, now, R_SESSION);
      if (r == R_NONE) r = run_stage(msg_tab, skey, mkey, mrate, mburst, now, R_MESSAGE);
      if (r == R_NONE) r = run_stage(inst_tab, ikey, '0, inst_rate_q, inst_burst_q, now,
                                     R_INSTANCE);
    end
    v.allowed = (r == R_NONE);
    v.reason = r;
    return v;
  endfunction

  // drive one item, wait for acceptance, record the expected verdict
  task automatic send_message(input logic [SKEY_W-1:0] skey, input logic [IKEY_W-1:0] ikey,
                              input logic [MKEY_W-1:0] mkey, input logic [RATE_W-1:0] mrate,
                              input logic [TIME_W-1:0] now);
    if (send_gaps && $urandom_range(3) == 0) repeat ($urandom_range(1, 7)) @(posedge clk);
    in_valid <= 1'b1;
    in_session_key <= skey;
    in_instance_key <= ikey;
    in_message_key <= mkey;
    in_message_rate <= mrate;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(admit_message(skey, ikey, mkey, mrate, now));
    in_valid <= 1'b0;
    // the block does not take another item right after taking one
    @(posedge clk);
  endtask

  // wait until idle, then write a register
  task automatic write_reg(input cfg_idx_t idx, input logic [RATE_W-1:0] val);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SESSION_RATE:   sess_rate_q = val;
      CFG_SESSION_BURST:  sess_burst_q = val;
      CFG_INSTANCE_RATE:  inst_rate_q = val;
      CFG_INSTANCE_BURST: inst_burst_q = val;
    endcase
  endtask

  // receiver ready with random stall bursts and an optional long hold
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (recv_hold) out_ready <= 1'b0;
    else if (recv_gaps && $urandom_range(3) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report("unexpected result", 32'd0, 32'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_allowed !== want.allowed)
          report("allowed", 32'(out_allowed), 32'(want.allowed));
        if (out_reason !== want.reason)
          report("reason", 32'(out_reason), 32'(want.reason));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // invalid fields, field extremes, fresh and exhausted buckets, backwards time
  task automatic test_directed();
    send_message('0, 64'd1, 32'd1, 16'd1, 64'd5);
    send_message(64'd1, '0, 32'd1, 16'd1, 64'd5);
    send_message(64'd1, 64'd1, '0, 16'd1, 64'd5);
    send_message(64'd1, 64'd1, 32'd1, '0, 64'd5);
    send_message(64'd1, 64'd1, 32'd1, 16'd1, '0);
    send_message('1, '1, '1, '1, '1);
    send_message(64'd7, 64'd7, 32'd3, 16'd1, 64'd100);
    send_message(64'd7, 64'd7, 32'd3, 16'd1, 64'd100);
    send_message(64'd7, 64'd7, 32'd3, 16'd1, 64'd100);
    send_message(64'd7, 64'd7, 32'd3, 16'd1, 64'd101);
    send_message(64'd7, 64'd7, 32'd3, 16'd1, 64'd50);
    send_message(64'd7, 64'd7, 32'd3, 16'h8000, 64'd200);
    send_message(64'd8, 64'd7, 32'd4, 16'h8000, '1);
    send_message('1, 64'd9, 32'd4, 16'd3, 64'd1);
    send_message(64'd8, 64'd7, 32'd4, 16'h8000, 64'd1);
  endtask

  // lowered bursts, zero bursts, max rates
  task automatic test_config_extremes();
    write_reg(CFG_SESSION_BURST, 16'd0);
    write_reg(CFG_INSTANCE_BURST, 16'd1);
    for (int i = 0; i < 6; i++) send_message(64'd7, 64'd7, 32'd3, 16'd5, 64'd300 + i);
    send_message(64'd77, 64'd78, 32'd3, 16'd5, 64'd400);
    write_reg(CFG_SESSION_RATE, 16'hFFFF);
    write_reg(CFG_SESSION_BURST, 16'hFFFF);
    write_reg(CFG_INSTANCE_RATE, 16'hFFFF);
    write_reg(CFG_INSTANCE_BURST, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_message(64'd7, 64'd7, 32'd3, 16'd5, 64'd1000 + i);
    send_message(64'd7, 64'd7, 32'd3, 16'd5, '1);
    write_reg(CFG_SESSION_RATE, 16'd1);
    write_reg(CFG_INSTANCE_RATE, 16'd1);
    write_reg(CFG_SESSION_BURST, 16'd2);
    write_reg(CFG_INSTANCE_BURST, 16'd3);
  endtask

  // send more distinct keys than a table has slots
  task automatic test_table_full();
    for (int i = 0; i < SLOTS + 4; i++)
      send_message(64'h1000 + i, 64'h2000 + i, 32'd9, 16'd2, 64'd5000);
  endtask

  // mostly pooled keys over advancing time; some noise and backwards steps
  task automatic run_random(input int count);
    logic [SKEY_W-1:0] sk;
    logic [IKEY_W-1:0] ik;
    logic [MKEY_W-1:0] mk;
    logic [RATE_W-1:0] mr;
    logic [TIME_W-1:0] now;
    for (int n = 0; n < count; n++) begin
      sk = sess_pool[$urandom_range(7)];
      ik = inst_pool[$urandom_range(7)];
      mk = $urandom_range(1, 4);
      mr = $urandom_range(1, 3) == 1 ? 16'($urandom) : 16'($urandom_range(1, 40));
      clock_ms = clock_ms + $urandom_range(0, 30);
      now = clock_ms;
      case ($urandom_range(19))
        0: begin sk = rand64(); ik = rand64(); mk = $urandom; end
        1: now = clock_ms - $urandom_range(1, 20);
        2: now = rand64();
        3: case ($urandom_range(4))
             0: sk = '0;
             1: ik = '0;
             2: mk = '0;
             3: mr = '0;
             default: now = '0;
           endcase
        default: ;
      endcase
      send_message(sk, ik, mk, mr, now);
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (2000) @(posedge clk);
        recv_hold = 1'b0;
      end
      run_random(20);
    join
  endtask

  initial begin
    sess_rate_q = SESSION_RATE_RST;
    sess_burst_q = SESSION_BURST_RST;
    inst_rate_q = INSTANCE_RATE_RST;
    inst_burst_q = INSTANCE_BURST_RST;
    foreach (sess_tab[i]) begin
      sess_tab[i].used = 0; msg_tab[i].used = 0; inst_tab[i].used = 0;
    end
    clock_ms = 64'd10000;
    for (int i = 0; i < 8; i++) begin
      sess_pool[i] = rand64() | 64'd1;
      inst_pool[i] = rand64() | 64'd1;
    end
    sess_pool[0] = '1;
    inst_pool[0] = '1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    run_random(500);
    write_reg(CFG_SESSION_RATE, 16'd80);
    write_reg(CFG_SESSION_BURST, 16'd160);
    write_reg(CFG_INSTANCE_RATE, 16'd160);
    write_reg(CFG_INSTANCE_BURST, 16'd256);
    test_table_full();
    test_backpressure();
    run_random(600);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_random(550);

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
